/* rtl/fix_tag_value_field_parser_defines.svh */
// Assertion macros shared by the tag=value parser RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef FIX_TAG_VALUE_FIELD_PARSER_DEFINES_SVH
`define FIX_TAG_VALUE_FIELD_PARSER_DEFINES_SVH
`ifndef ASSERT_OFF
// Plain clocked property, checked outside reset.
`define FTVP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication from a trigger to a same-cycle consequence.
`define FTVP_ASSERT_IMPL(lbl, clk, rst, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);
`else
`define FTVP_ASSERT(lbl, clk, rst, prop, msg)
`define FTVP_ASSERT_IMPL(lbl, clk, rst, trig, cons, msg)
`endif
`endif

/* rtl/ftvp_pkg.sv */
// Shared types and constants for the FIX tag=value field parser.
// No dependencies; used by the interfaces and all RTL modules.
package ftvp_pkg;

  localparam int BYTE_W    = 8;
  localparam int NUM_W     = 24;
  localparam int NUM_REGS  = 4;
  localparam int REG_IDX_W = 2;
  localparam int PHASE_W   = 3;
  localparam int KIND_W    = 2;
  localparam int ERR_W     = 3;

  localparam logic [NUM_W-1:0]  NUM_MAX  = 24'hFF_FFFF;
  localparam logic [BYTE_W-1:0] SEP_CHAR = 8'h01;
  localparam logic [BYTE_W-1:0] EQ_CHAR  = 8'h3D;
  localparam logic [BYTE_W-1:0] DIGIT_LO = 8'h30;
  localparam logic [BYTE_W-1:0] DIGIT_HI = 8'h39;

  // parse phases; undefined codes behave as PH_TAG
  localparam logic [PHASE_W-1:0] PH_TAG   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_VALUE = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DATA  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SEP   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SKIP  = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VALUE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIELD = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
  localparam logic [ERR_W-1:0] ERR_NO_EQ    = 3'd1;
  localparam logic [ERR_W-1:0] ERR_EQ_LAST  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_NO_PRED  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_NO_SEP   = 3'd4;

  // decimal accumulator: saturating number plus "stopped" flag
  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] value;
  } num_acc_t;

endpackage

/* rtl/ftvp_if.sv */
// Channel interfaces for the parser: message bytes in, parse results out.
// Depends on ftvp_pkg for field widths.
interface ftvp_msg_if;
  logic                       valid;
  logic                       ready;
  logic [ftvp_pkg::BYTE_W-1:0] data_byte;
  logic                       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ftvp_field_if;
  logic                        valid;
  logic                        ready;
  logic [ftvp_pkg::KIND_W-1:0] kind;
  logic [ftvp_pkg::NUM_W-1:0]  result_tag;
  logic [ftvp_pkg::BYTE_W-1:0] value_byte;
  logic [ftvp_pkg::ERR_W-1:0]  error_code;
  logic                        message_end;

  modport source (output valid, output kind, output result_tag, output value_byte,
                  output error_code, output message_end, input ready);
  modport sink   (input valid, input kind, input result_tag, input value_byte,
                  input error_code, input message_end, output ready);
endinterface

/* rtl/fix_tag_value_field_parser.sv */
// FIX tag=value field parser top level: one message byte per transfer, one result per byte.
// Depends on ftvp_pkg, ftvp_msg_if/ftvp_field_if, ftvp_digit_acc and the assertion header.
//
// Bytes enter an input register; one pass of parse logic then updates the parse state
// and loads the result register. Throughput is one byte per clock while the result side
// accepts: the whole per-byte update (one x10 digit accumulate, the data-tag compares and
// the phase step) is combinational, so each byte sees the state left by the byte before
// it. A byte passes the input register and then the result register. The input register
// takes a new byte while a finished result waits, so the input stalls only when both
// registers are full. The user must have data-tag registers written through
// write_en/reg_index/write_data only while the parser is idle; the block does not enforce
// this. Zero disables a register, and only the first NUM_DATA_TAGS registers are compared.
`include "fix_tag_value_field_parser_defines.svh"

module fix_tag_value_field_parser #(
  parameter int NUM_DATA_TAGS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  ftvp_msg_if.sink                       msg,
  ftvp_field_if.source                   field,
  input  logic                           write_en,
  input  logic [ftvp_pkg::REG_IDX_W-1:0] reg_index,
  input  logic [ftvp_pkg::NUM_W-1:0]     write_data
);

  localparam int NUM_CMP = (NUM_DATA_TAGS < ftvp_pkg::NUM_REGS) ? NUM_DATA_TAGS
                                                                : ftvp_pkg::NUM_REGS;

  // configuration registers
  logic [ftvp_pkg::NUM_W-1:0] data_tag [ftvp_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ftvp_pkg::NUM_REGS; i++) data_tag[i] <= '0;
    end else if (write_en) begin
      data_tag[reg_index] <= write_data;
    end
  end

  // input register
  logic                        s1_valid;
  logic [ftvp_pkg::BYTE_W-1:0] s1_byte;
  logic                        s1_last;
  logic                        s1_fire;
  logic                        out_valid;

  assign s1_fire   = s1_valid && (!out_valid || field.ready);
  assign msg.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (msg.ready) begin
      s1_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      s1_byte <= msg.data_byte;
      s1_last <= msg.last_byte;
    end
  end

  // parse state
  logic [ftvp_pkg::PHASE_W-1:0] phase, phase_next;
  ftvp_pkg::num_acc_t           tag_acc, tag_acc_next;
  ftvp_pkg::num_acc_t           val_acc, val_acc_next;
  logic [ftvp_pkg::NUM_W-1:0]   pred_value, pred_value_next;
  logic                         prev_seen, prev_seen_next;
  logic [ftvp_pkg::NUM_W-1:0]   remaining, remaining_next;

  // shared digit accumulator, fed by the tag or the value number
  ftvp_pkg::num_acc_t acc_in, acc_out;
  logic               in_value;

  assign in_value = (phase == ftvp_pkg::PH_VALUE) || (phase == ftvp_pkg::PH_DATA);
  assign acc_in   = in_value ? val_acc : tag_acc;

  ftvp_digit_acc u_digit (
    .acc       (acc_in),
    .data_byte (s1_byte),
    .acc_next  (acc_out)
  );

  // data-tag match on the current tag number
  logic tag_match;
  always_comb begin
    tag_match = 1'b0;
    for (int i = 0; i < NUM_CMP; i++) begin
      if ((data_tag[i] != '0) && (data_tag[i] == tag_acc.value)) tag_match = 1'b1;
    end
  end

  // per-byte step
  logic [ftvp_pkg::KIND_W-1:0] kind_next;
  logic [ftvp_pkg::ERR_W-1:0]  err_next;
  logic [ftvp_pkg::BYTE_W-1:0] vbyte_next;
  logic [ftvp_pkg::NUM_W-1:0]  tag_out_next;
  logic [ftvp_pkg::NUM_W-1:0]  rem_dec;

  assign rem_dec = remaining - 1'b1;

  always_comb begin
    phase_next      = phase;
    tag_acc_next    = tag_acc;
    val_acc_next    = val_acc;
    pred_value_next = pred_value;
    prev_seen_next  = prev_seen;
    remaining_next  = remaining;
    kind_next       = ftvp_pkg::KIND_NONE;
    err_next        = ftvp_pkg::ERR_NONE;
    vbyte_next      = '0;

    unique case (phase)
      ftvp_pkg::PH_VALUE: begin
        if (s1_byte == ftvp_pkg::SEP_CHAR) begin
          kind_next = ftvp_pkg::KIND_FIELD;
        end else begin
          kind_next    = ftvp_pkg::KIND_VALUE;
          vbyte_next   = s1_byte;
          val_acc_next = acc_out;
          if (s1_last) err_next = ftvp_pkg::ERR_NO_SEP;
        end
      end
      ftvp_pkg::PH_DATA: begin
        kind_next      = ftvp_pkg::KIND_VALUE;
        vbyte_next     = s1_byte;
        val_acc_next   = acc_out;
        remaining_next = rem_dec;
        if (rem_dec == '0) phase_next = ftvp_pkg::PH_SEP;
        if (s1_last) err_next = ftvp_pkg::ERR_NO_SEP;
      end
      ftvp_pkg::PH_SEP: begin
        if (s1_byte == ftvp_pkg::SEP_CHAR) kind_next = ftvp_pkg::KIND_FIELD;
        else                               err_next  = ftvp_pkg::ERR_NO_SEP;
      end
      ftvp_pkg::PH_SKIP: begin
      end
      default: begin
        if (s1_byte == ftvp_pkg::EQ_CHAR) begin
          val_acc_next = '0;
          if (s1_last) begin
            err_next = ftvp_pkg::ERR_EQ_LAST;
          end else if (tag_match) begin
            if (!prev_seen) begin
              err_next = ftvp_pkg::ERR_NO_PRED;
            end else begin
              remaining_next = pred_value;
              phase_next     = (pred_value != '0) ? ftvp_pkg::PH_DATA : ftvp_pkg::PH_SEP;
            end
          end else begin
            phase_next = ftvp_pkg::PH_VALUE;
          end
        end else begin
          tag_acc_next = acc_out;
          if (s1_last) err_next = ftvp_pkg::ERR_NO_EQ;
        end
      end
    endcase

    tag_out_next = tag_acc_next.value;

    // error or field completion
    if (err_next != ftvp_pkg::ERR_NONE) begin
      kind_next  = ftvp_pkg::KIND_ERROR;
      vbyte_next = '0;
      phase_next = ftvp_pkg::PH_SKIP;
    end else if (kind_next == ftvp_pkg::KIND_FIELD) begin
      pred_value_next = val_acc_next.value;
      prev_seen_next  = 1'b1;
      phase_next      = ftvp_pkg::PH_TAG;
      tag_acc_next    = '0;
    end

    // message end clears all parse state
    if (s1_last) begin
      phase_next      = ftvp_pkg::PH_TAG;
      tag_acc_next    = '0;
      val_acc_next    = '0;
      pred_value_next = '0;
      prev_seen_next  = 1'b0;
      remaining_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ftvp_pkg::PH_TAG;
      tag_acc    <= '0;
      val_acc    <= '0;
      pred_value <= '0;
      prev_seen  <= 1'b0;
      remaining  <= '0;
    end else if (s1_fire) begin
      phase      <= phase_next;
      tag_acc    <= tag_acc_next;
      val_acc    <= val_acc_next;
      pred_value <= pred_value_next;
      prev_seen  <= prev_seen_next;
      remaining  <= remaining_next;
    end
  end

  // result register
  logic [ftvp_pkg::KIND_W-1:0] kind_q;
  logic [ftvp_pkg::NUM_W-1:0]  tag_q;
  logic [ftvp_pkg::BYTE_W-1:0] vbyte_q;
  logic [ftvp_pkg::ERR_W-1:0]  err_q;
  logic                        end_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (field.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      kind_q  <= kind_next;
      tag_q   <= tag_out_next;
      vbyte_q <= vbyte_next;
      err_q   <= err_next;
      end_q   <= s1_last;
    end
  end

  assign field.valid       = out_valid;
  assign field.kind        = kind_q;
  assign field.result_tag  = tag_q;
  assign field.value_byte  = vbyte_q;
  assign field.error_code  = err_q;
  assign field.message_end = end_q;

  // checks
  `FTVP_ASSERT_IMPL(a_err_code_on_error, clk, rst,
    out_valid && (kind_q == ftvp_pkg::KIND_ERROR), err_q != ftvp_pkg::ERR_NONE,
    "error result without error code")
  `FTVP_ASSERT_IMPL(a_no_code_otherwise, clk, rst,
    out_valid && (kind_q != ftvp_pkg::KIND_ERROR), err_q == ftvp_pkg::ERR_NONE,
    "error code on non-error result")
  `FTVP_ASSERT_IMPL(a_vbyte_only_value, clk, rst,
    out_valid && (kind_q != ftvp_pkg::KIND_VALUE), vbyte_q == '0,
    "value byte set on non-value result")
  `FTVP_ASSERT_IMPL(a_data_has_count, clk, rst,
    phase == ftvp_pkg::PH_DATA, remaining != '0,
    "data phase with zero bytes remaining")
  `FTVP_ASSERT(a_msg_end_clears, clk, rst,
    s1_fire && s1_last |=> (phase == ftvp_pkg::PH_TAG) && !prev_seen && (remaining == '0),
    "parse state not cleared after message end")

endmodule

/* rtl/ftvp_digit_acc.sv */
// Saturating decimal digit accumulator: num*10 + digit, clamped to 24 bits.
// Depends on ftvp_pkg (num_acc_t, constants).
module ftvp_digit_acc (
  input  ftvp_pkg::num_acc_t          acc,
  input  logic [ftvp_pkg::BYTE_W-1:0] data_byte,
  output ftvp_pkg::num_acc_t          acc_next
);

  localparam int PROD_W = ftvp_pkg::NUM_W + 4;

  logic              is_digit;
  logic [3:0]        digit;
  logic [PROD_W-1:0] prod;

  assign is_digit = (data_byte >= ftvp_pkg::DIGIT_LO) && (data_byte <= ftvp_pkg::DIGIT_HI);
  assign digit    = data_byte[3:0];

  // x10 as shift-and-add
  assign prod = ({4'd0, acc.value} << 3) + ({4'd0, acc.value} << 1) + {{(PROD_W-4){1'b0}}, digit};

  always_comb begin
    acc_next = acc;
    if (!acc.done) begin
      if (is_digit) begin
        acc_next.value = (prod > {4'd0, ftvp_pkg::NUM_MAX}) ? ftvp_pkg::NUM_MAX
                                                            : prod[ftvp_pkg::NUM_W-1:0];
      end else begin
        acc_next.done = 1'b1;
      end
    end
  end

endmodule

/* dv/tb_top.sv */
// Self-checking bench for the FIX tag=value field parser: random and directed
// message bytes in, per-byte parse results checked against a cycle-free predictor.
// Depends on ftvp_pkg, the ftvp_msg_if/ftvp_field_if channels and the parser RTL.
module tb_top;

  localparam int NUM_DATA_TAGS = 4;
  localparam int HOLD_CYCLES   = 60;
  localparam int PHASE_BYTES   = 180;
  localparam int DRAIN_LIMIT   = 2000;

  // data-tag register indexes
  localparam logic [ftvp_pkg::REG_IDX_W-1:0] REG_DATA_TAG_A = 2'd0;
  localparam logic [ftvp_pkg::REG_IDX_W-1:0] REG_DATA_TAG_B = 2'd1;
  localparam logic [ftvp_pkg::REG_IDX_W-1:0] REG_DATA_TAG_C = 2'd2;
  localparam logic [ftvp_pkg::REG_IDX_W-1:0] REG_DATA_TAG_D = 2'd3;

  typedef struct packed {
    logic [ftvp_pkg::KIND_W-1:0] kind;
    logic [ftvp_pkg::NUM_W-1:0]  result_tag;
    logic [ftvp_pkg::BYTE_W-1:0] value_byte;
    logic [ftvp_pkg::ERR_W-1:0]  error_code;
    logic                        message_end;
  } parse_result_t;

  // Tracks parse state per accepted byte and holds the results still owed
  class field_parse_tracker;
    logic [ftvp_pkg::NUM_W-1:0]   data_tag [ftvp_pkg::NUM_REGS];
    logic [ftvp_pkg::PHASE_W-1:0] phase;
    logic [ftvp_pkg::NUM_W-1:0]   tag_num, value_num, pred_value, remaining;
    bit                           tag_stop, value_stop, prev_seen;
    parse_result_t                pending_results[$];
    int unsigned                  mismatches;
    int unsigned                  kind_seen [4];

    function new();
      foreach (data_tag[i]) data_tag[i] = '0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      mismatches = 0;
      clear_message();
    endfunction

    function void set_tag(logic [ftvp_pkg::REG_IDX_W-1:0] idx,
                          logic [ftvp_pkg::NUM_W-1:0] val);
      data_tag[idx] = val;
    endfunction

    function void clear_message();
      phase      = ftvp_pkg::PH_TAG;
      tag_num    = '0;
      tag_stop   = 0;
      value_num  = '0;
      value_stop = 0;
      pred_value = '0;
      prev_seen  = 0;
      remaining  = '0;
    endfunction

    // decimal accumulate, stops at first non-digit, saturates at 24 bits
    function void push_digit(inout logic [ftvp_pkg::NUM_W-1:0] num, inout bit stop,
                             input logic [ftvp_pkg::BYTE_W-1:0] b);
      logic [31:0] n;
      if (stop) return;
      if (b >= ftvp_pkg::DIGIT_LO && b <= ftvp_pkg::DIGIT_HI) begin
        n = num * 10 + (b - ftvp_pkg::DIGIT_LO);
        num = (n > ftvp_pkg::NUM_MAX) ? ftvp_pkg::NUM_MAX : n[ftvp_pkg::NUM_W-1:0];
      end else begin
        stop = 1;
      end
    endfunction

    function bit matches_data_tag(logic [ftvp_pkg::NUM_W-1:0] t);
      for (int i = 0; i < NUM_DATA_TAGS && i < ftvp_pkg::NUM_REGS; i++)
        if (data_tag[i] != '0 && data_tag[i] == t) return 1;
      return 0;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // one accepted byte -> one expected result
    function void accept_byte(logic [ftvp_pkg::BYTE_W-1:0] b, logic last);
      parse_result_t r;
      r = '0;
      case (phase)
        ftvp_pkg::PH_VALUE: begin
          if (b == ftvp_pkg::SEP_CHAR) begin
            r.kind = ftvp_pkg::KIND_FIELD;
          end else begin
            r.kind = ftvp_pkg::KIND_VALUE;
            r.value_byte = b;
            push_digit(value_num, value_stop, b);
            if (last) r.error_code = ftvp_pkg::ERR_NO_SEP;
          end
        end
        ftvp_pkg::PH_DATA: begin
          r.kind = ftvp_pkg::KIND_VALUE;
          r.value_byte = b;
          push_digit(value_num, value_stop, b);
          remaining = remaining - 1'b1;
          if (remaining == '0) phase = ftvp_pkg::PH_SEP;
          if (last) r.error_code = ftvp_pkg::ERR_NO_SEP;
        end
        ftvp_pkg::PH_SEP: begin
          if (b == ftvp_pkg::SEP_CHAR) r.kind = ftvp_pkg::KIND_FIELD;
          else r.error_code = ftvp_pkg::ERR_NO_SEP;
        end
        ftvp_pkg::PH_SKIP: ;
        default: begin
          if (b == ftvp_pkg::EQ_CHAR) begin
            value_num  = '0;
            value_stop = 0;
            if (last) begin
              r.error_code = ftvp_pkg::ERR_EQ_LAST;
            end else if (matches_data_tag(tag_num)) begin
              if (!prev_seen) begin
                r.error_code = ftvp_pkg::ERR_NO_PRED;
              end else begin
                remaining = pred_value;
                phase = (remaining != '0) ? ftvp_pkg::PH_DATA : ftvp_pkg::PH_SEP;
              end
            end else begin
              phase = ftvp_pkg::PH_VALUE;
            end
          end else begin
            push_digit(tag_num, tag_stop, b);
            if (last) r.error_code = ftvp_pkg::ERR_NO_EQ;
          end
        end
      endcase

      r.result_tag = tag_num;
      if (r.error_code != ftvp_pkg::ERR_NONE) begin
        r.kind = ftvp_pkg::KIND_ERROR;
        r.value_byte = '0;
        phase = ftvp_pkg::PH_SKIP;
      end else if (r.kind == ftvp_pkg::KIND_FIELD) begin
        pred_value = value_num;
        prev_seen  = 1;
        phase      = ftvp_pkg::PH_TAG;
        tag_num    = '0;
        tag_stop   = 0;
      end
      r.message_end = last;
      if (last) clear_message();
      pending_results.push_back(r);
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // compare one result transfer with the oldest expectation
    task check_result(parse_result_t got);
      parse_result_t want;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind=%0d tag=%0d", got.kind,
                                got.result_tag));
        return;
      end
      want = pending_results.pop_front();
      kind_seen[want.kind]++;
      if (got.kind !== want.kind)
        flag_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.result_tag !== want.result_tag)
        flag_mismatch($sformatf("result_tag %0d, want %0d", got.result_tag,
                                want.result_tag));
      if (got.value_byte !== want.value_byte)
        flag_mismatch($sformatf("value_byte %0h, want %0h", got.value_byte, want.value_byte));
      if (got.error_code !== want.error_code)
        flag_mismatch($sformatf("error_code %0d, want %0d", got.error_code, want.error_code));
      if (got.message_end !== want.message_end)
        flag_mismatch($sformatf("message_end %0b, want %0b", got.message_end, want.message_end));
    endtask
  endclass

  logic                           clk;
  logic                           rst;
  logic                           write_en;
  logic [ftvp_pkg::REG_IDX_W-1:0] reg_index;
  logic [ftvp_pkg::NUM_W-1:0]     write_data;

  ftvp_msg_if   msg_ch ();
  ftvp_field_if res_ch ();

  fix_tag_value_field_parser #(
    .NUM_DATA_TAGS(NUM_DATA_TAGS)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .msg        (msg_ch),
    .field      (res_ch),
    .write_en   (write_en),
    .reg_index  (reg_index),
    .write_data (write_data)
  );

  field_parse_tracker tracker;

  bit                          quiet;      // no idling on either side
  bit                          pressure;   // sender offers back to back
  bit                          hold_req;   // ask receiver for a long hold-off
  int unsigned                 bytes_sent;
  int unsigned                 messages_sent;
  logic [ftvp_pkg::NUM_W-1:0]  tag_cfg [ftvp_pkg::NUM_REGS];
  logic [ftvp_pkg::BYTE_W-1:0] frame[$];

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stall bursts plus one long hold-off on request
  initial begin : result_sink
    int hold_left;
    int stall_left;
    parse_result_t got;
    hold_left  = 0;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        got.kind        = res_ch.kind;
        got.result_tag  = res_ch.result_tag;
        got.value_byte  = res_ch.value_byte;
        got.error_code  = res_ch.error_code;
        got.message_end = res_ch.message_end;
        tracker.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 0;
        hold_left = HOLD_CYCLES - 1;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // one byte transfer, with an optional idle burst ahead of it
  task send_byte(input logic [ftvp_pkg::BYTE_W-1:0] b, input logic last, input bit no_gaps);
    if (!no_gaps && !quiet && !pressure && $urandom_range(0, 5) == 0) begin
      msg_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    msg_ch.valid     <= 1'b1;
    msg_ch.data_byte <= b;
    msg_ch.last_byte <= last;
    do @(posedge clk); while (!msg_ch.ready);
    tracker.accept_byte(b, last);
    bytes_sent++;
  endtask

  // stop offering and wait until every owed result has come back
  task drain_results();
    msg_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  // send the built frame; pause_at >= 0 drains before that byte
  task send_frame(input int pause_at);
    bit no_gaps;
    no_gaps = ($urandom_range(0, 3) == 0);
    foreach (frame[i]) begin
      if (i == pause_at) drain_results();
      send_byte(frame[i], i == frame.size() - 1, no_gaps);
    end
    messages_sent++;
  endtask

  task put_reg(input logic [ftvp_pkg::REG_IDX_W-1:0] idx,
               input logic [ftvp_pkg::NUM_W-1:0] val);
    write_en   <= 1'b1;
    reg_index  <= idx;
    write_data <= val;
    @(posedge clk);
    tag_cfg[idx] = val;
    tracker.set_tag(idx, val);
  endtask

  // all four data-tag registers, back to back; parser must be idle
  task write_tags(input logic [ftvp_pkg::NUM_W-1:0] a, input logic [ftvp_pkg::NUM_W-1:0] b,
                  input logic [ftvp_pkg::NUM_W-1:0] c, input logic [ftvp_pkg::NUM_W-1:0] d);
    put_reg(REG_DATA_TAG_A, a);
    put_reg(REG_DATA_TAG_B, b);
    put_reg(REG_DATA_TAG_C, c);
    put_reg(REG_DATA_TAG_D, d);
    write_en <= 1'b0;
  endtask

  // frame building; '|' in text stands for the separator
  function void put_text(string s);
    for (int i = 0; i < s.len(); i++)
      frame.push_back((s[i] == "|") ? ftvp_pkg::SEP_CHAR : s[i]);
  endfunction

  function void put_number(longint unsigned n);
    put_text($sformatf("%0d", n));
  endfunction

  function logic [ftvp_pkg::BYTE_W-1:0] plain_byte();
    logic [ftvp_pkg::BYTE_W-1:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == ftvp_pkg::SEP_CHAR) ? 8'h00 : b;
  endfunction

  function logic [ftvp_pkg::NUM_W-1:0] pick_data_tag();
    logic [ftvp_pkg::NUM_W-1:0] live[$];
    for (int i = 0; i < NUM_DATA_TAGS; i++)
      if (tag_cfg[i] != '0) live.push_back(tag_cfg[i]);
    if (live.size() == 0) return '0;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  function void put_tag();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) begin
      put_number($urandom_range(1, 999));
    end else if (sel < 88) begin
      // overlong tag, saturates
      put_number($urandom_range(100000000, 999999999));
    end else if (sel < 92) begin
      // empty tag
    end else begin
      put_number($urandom_range(0, 99));
      put_text("a");
      put_number($urandom_range(0, 99));
    end
  endfunction

  function void put_plain_value();
    int unsigned len;
    bit digits;
    len = $urandom_range(0, 5);
    digits = 1'($urandom_range(0, 1));
    repeat (len)
      frame.push_back(digits ? 8'(ftvp_pkg::DIGIT_LO + $urandom_range(0, 9)) : plain_byte());
  endfunction

  // length field followed by its length-counted data field
  function void put_data_pair(logic [ftvp_pkg::NUM_W-1:0] dtag);
    int unsigned len;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
    put_number($urandom_range(1, 999));
    put_text("=");
    put_number(len);
    if ($urandom_range(0, 3) == 0) put_text("x7");
    put_text("|");
    put_number(dtag);
    put_text("=");
    repeat (len) frame.push_back(8'($urandom_range(0, 255)));
    put_text("|");
  endfunction

  function void put_wellformed();
    logic [ftvp_pkg::NUM_W-1:0] dtag;
    repeat ($urandom_range(1, 6)) begin
      dtag = pick_data_tag();
      if (dtag != '0 && $urandom_range(0, 2) == 0) begin
        put_data_pair(dtag);
      end else begin
        put_tag();
        put_text("=");
        put_plain_value();
        put_text("|");
      end
    end
  endfunction

  // mostly well-formed messages, the rest truncated, led by a data tag with no length field, corrupted or noise
  function void build_message();
    int unsigned sel;
    int unsigned keep;
    logic [ftvp_pkg::NUM_W-1:0] dtag;
    frame.delete();
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      put_wellformed();
    end else if (sel < 82) begin
      put_wellformed();
      keep = $urandom_range(1, frame.size());
      while (frame.size() > keep) void'(frame.pop_back());
    end else if (sel < 89) begin
      dtag = pick_data_tag();
      if (dtag != '0) begin
        put_number(dtag);
        put_text("=ab|");
      end
      put_wellformed();
    end else if (sel < 95) begin
      put_wellformed();
      frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
    end else begin
      repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task run_random(input int unsigned target, input bit with_hold, input bit with_pause);
    int unsigned start;
    int n;
    start = bytes_sent;
    n = 0;
    while (bytes_sent - start < target) begin
      build_message();
      if (with_hold && n == 2) begin
        pressure = 1;
        hold_req = 1;
        send_frame(-1);
        build_message();
        send_frame(-1);
        pressure = 0;
      end else if (with_pause && n == 4 && frame.size() > 2) begin
        send_frame(frame.size() / 2);
      end else begin
        send_frame(-1);
      end
      n++;
    end
  endtask

  // main sequence
  initial begin : stimulus
    int waited;
    tracker       = new();
    quiet         = 0;
    pressure      = 0;
    hold_req      = 0;
    bytes_sent    = 0;
    messages_sent = 0;
    foreach (tag_cfg[i]) tag_cfg[i] = '0;

    rst              <= 1'b1;
    write_en         <= 1'b0;
    reg_index        <= '0;
    write_data       <= '0;
    msg_ch.valid     <= 1'b0;
    msg_ch.data_byte <= '0;
    msg_ch.last_byte <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // setting one: three data tags, one slot unused
    write_tags(24'd95, 24'd89, 24'd0, 24'd213);

    // directed: error codes, zero-length and separator-bearing data fields
    frame.delete(); put_text("=");                   send_frame(-1);
    frame.delete(); put_text("1"); frame.push_back(8'h00); send_frame(-1);
    frame.delete(); put_text("95=q");                send_frame(-1);
    frame.delete(); put_text("7=2|89="); frame.push_back(8'hFF);
    put_text("||");                                  send_frame(-1);
    frame.delete(); put_text("4=0|213=y");           send_frame(-1);

    run_random(PHASE_BYTES, 1, 0);

    // setting two: extremes, largest tag and smallest tag
    drain_results();
    repeat (4) @(posedge clk);
    write_tags(ftvp_pkg::NUM_MAX, 24'd1, 24'd0, 24'd0);
    run_random(PHASE_BYTES, 0, 1);

    // setting three: all data tags off
    drain_results();
    repeat (4) @(posedge clk);
    write_tags(24'd0, 24'd0, 24'd0, 24'd0);
    run_random(PHASE_BYTES, 0, 0);

    // setting four: random small tags, no idling from here on
    drain_results();
    repeat (4) @(posedge clk);
    write_tags(24'($urandom_range(1, 999)), 24'($urandom_range(1, 999)),
               24'($urandom_range(1, 999)), 24'($urandom_range(1, 999)));
    quiet = 1;
    run_random(PHASE_BYTES, 0, 0);

    // end of run: wait for owed results, then flag any that never arrived
    msg_ch.valid <= 1'b0;
    waited = 0;
    while (tracker.outstanding() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (tracker.outstanding() != 0)
      tracker.flag_mismatch($sformatf("%0d results never arrived", tracker.outstanding()));

    $display("Covered %0d messages, %0d bytes, across four data-tag settings",
             messages_sent, bytes_sent);
    $display("Checked %0d value bytes, %0d fields, %0d errors, %0d idle results",
             tracker.kind_seen[ftvp_pkg::KIND_VALUE], tracker.kind_seen[ftvp_pkg::KIND_FIELD],
             tracker.kind_seen[ftvp_pkg::KIND_ERROR], tracker.kind_seen[ftvp_pkg::KIND_NONE]);
    if (tracker.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
